// ===== hdl/pareto_front_archive_macros.svh =====
`ifndef PARETO_FRONT_ARCHIVE_MACROS_SVH
`define PARETO_FRONT_ARCHIVE_MACROS_SVH

// Assertion helpers for the Pareto archive. Both expect clk and rst_n in scope.

// The consequent must hold in the same cycle as the antecedent.
`define PFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pareto_front_archive: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pareto_front_archive: next-cycle check failed");

`endif

// ===== hdl/pfa_pkg.sv =====
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int MAX_ENTRIES    = 64;
    localparam int MAX_OBJECTIVES = 4;

    // Objective fields carried on the ports, whatever MAX_OBJECTIVES is.
    localparam int OBJ_FIELDS = 4;
    localparam int COUNT_W    = $clog2(MAX_ENTRIES + 1);
    localparam int NOBJ_W     = 3;
    localparam int ADDR_W     = 3;

    localparam logic REG_IDX_NUM_OBJECTIVES = 1'b0;
    localparam logic [NOBJ_W-1:0] NUM_OBJECTIVES_RESET = 3'd2;

    typedef enum logic [1:0] {
        OP_OFFER = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_EVAL    = 4'b0010,
        S_COMPACT = 4'b0100,
        S_DONE    = 4'b1000
    } state_t;

    typedef logic signed [31:0] obj_val_t;
    typedef obj_val_t [MAX_OBJECTIVES-1:0] obj_vec_t;

    typedef struct packed {
        op_t         operation;
        logic [5:0]  first_index;
        logic [5:0]  second_index;
        obj_val_t    obj_0;
        obj_val_t    obj_1;
        obj_val_t    obj_2;
        obj_val_t    obj_3;
        logic [5:0]  read_index;
    } req_t;

    typedef struct packed {
        logic        accepted;
        logic        overflow;
        logic [6:0]  set_size;
        logic        entry_valid;
        logic [5:0]  entry_first;
        logic [5:0]  entry_second;
        obj_val_t    entry_obj_0;
        obj_val_t    entry_obj_1;
        obj_val_t    entry_obj_2;
        obj_val_t    entry_obj_3;
    } rsp_t;

    typedef struct packed {
        logic [5:0]  first;
        logic [5:0]  second;
        obj_vec_t    obj;
    } entry_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic eval;
        logic compact;
        logic insert;
    } cell_ctl_t;

    function automatic obj_vec_t req_objs(req_t r);
        obj_val_t all [OBJ_FIELDS];
        obj_vec_t v;
        int       k;
        all[0] = r.obj_0;
        all[1] = r.obj_1;
        all[2] = r.obj_2;
        all[3] = r.obj_3;
        for (k = 0; k < MAX_OBJECTIVES; k++)
        begin
            v[k] = all[k];
        end
        return v;
    endfunction

    // Objectives beyond MAX_OBJECTIVES read back as zero.
    function automatic rsp_t fill_entry(rsp_t r, entry_t e);
        obj_val_t all [OBJ_FIELDS];
        rsp_t     o;
        int       k;
        for (k = 0; k < OBJ_FIELDS; k++)
        begin
            all[k] = '0;
        end
        for (k = 0; k < MAX_OBJECTIVES; k++)
        begin
            all[k] = e.obj[k];
        end
        o              = r;
        o.entry_valid  = 1'b1;
        o.entry_first  = e.first;
        o.entry_second = e.second;
        o.entry_obj_0  = all[0];
        o.entry_obj_1  = all[1];
        o.entry_obj_2  = all[2];
        o.entry_obj_3  = all[3];
        return o;
    endfunction

endpackage

// ===== hdl/pareto_front_archive.sv =====
`timescale 1ns / 1ps
// Sequence: every request is taken in S_IDLE and checked against all cells in S_EVAL; a read,
// clear, no-op or dominated offer then goes to S_DONE, while any other offer passes S_COMPACT,
// which closes one hole per cycle for each entry it removes and then inserts or overflows.
// The single result register is loaded in S_DONE; no new request is taken until then.
// Reset: the set is empty, num_objectives is 2, no result is pending; entries are not cleared.
`include "pareto_front_archive_macros.svh"

module pareto_front_archive (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  pfa_pkg::req_t                req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output pfa_pkg::rsp_t                rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pfa_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import pfa_pkg::*;

    // Control state.
    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [NOBJ_W-1:0]  num_objectives_reg, num_objectives_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // Payload registers: the item being worked on, the result being built, and the
    // output register that holds a finished result until the far side takes it.
    req_t item_reg, item_next;
    rsp_t res_reg, res_next;
    rsp_t rsp_reg, rsp_next;

    logic [NOBJ_W-1:0]    num_obj_eff;
    cell_ctl_t            ctl;
    entry_t               cand_entry;
    entry_t               cell_entry [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_valid, cell_removed, cell_hole, cell_dom;
    logic                 any_dom, any_removed, read_hit;
    entry_t               rd_entry;

    // ------------------------------------------------------------------
    // Configuration port. The single register sits at byte address 0;
    // paddr[2] is the register index, so address 4 is a write to nothing.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_NUM_OBJECTIVES) ? 32'(num_objectives_reg) : '0;

    always_comb
    begin
        num_objectives_next = num_objectives_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_IDX_NUM_OBJECTIVES))
        begin
            num_objectives_next = pwdata[NOBJ_W-1:0];
        end
    end

    // A count of zero compares one objective; a count above the maximum compares all.
    always_comb
    begin
        priority if (num_objectives_reg == '0)
        begin
            num_obj_eff = NOBJ_W'(1);
        end
        else if (num_objectives_reg > NOBJ_W'(MAX_OBJECTIVES))
        begin
            num_obj_eff = NOBJ_W'(MAX_OBJECTIVES);
        end
        else
        begin
            num_obj_eff = num_objectives_reg;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain. Cell 0 holds the newest entry. A cell is live when its
    // position is below the entry count. During an insert every cell takes
    // its upstream neighbor and cell 0 takes the candidate; during a
    // compaction step every cell at or behind the first hole takes its
    // downstream neighbor, which closes exactly one hole per cycle.
    // ------------------------------------------------------------------
    assign cand_entry.first  = item_reg.first_index;
    assign cand_entry.second = item_reg.second_index;
    assign cand_entry.obj    = req_objs(item_reg);

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        entry_t prev_e, next_e;
        logic   next_r, hole_i;

        assign cell_valid[g] = COUNT_W'(g) < count_reg;

        if (g == 0)
        begin : g_head
            assign prev_e = cand_entry;
            assign hole_i = 1'b0;
        end
        else
        begin : g_body
            assign prev_e = cell_entry[g-1];
            assign hole_i = cell_hole[g-1];
        end

        if (g == MAX_ENTRIES - 1)
        begin : g_tail
            assign next_e = '0;
            assign next_r = 1'b0;
        end
        else
        begin : g_inner
            assign next_e = cell_entry[g+1];
            assign next_r = cell_removed[g+1];
        end

        pfa_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .valid        (cell_valid[g]),
            .cand_obj     (cand_entry.obj),
            .num_obj      (num_obj_eff),
            .prev_entry   (prev_e),
            .next_entry   (next_e),
            .next_removed (next_r),
            .hole_in      (hole_i),
            .entry        (cell_entry[g]),
            .removed      (cell_removed[g]),
            .hole_out     (cell_hole[g]),
            .dom_cand     (cell_dom[g])
        );
    end

    assign any_dom     = |cell_dom;
    assign any_removed = cell_hole[MAX_ENTRIES-1];

    // Read select: each cell matches its own position, and the matches are
    // merged by an AND-OR tree.
    assign read_hit = int'(item_reg.read_index) < int'(count_reg);

    always_comb
    begin
        rd_entry = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (int'(item_reg.read_index) == i)
            begin
                rd_entry = rd_entry | cell_entry[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. One item is worked on at a time: it is evaluated against
    // every cell at once, then an offer that is not dominated compacts and inserts
    // or overflows, and the finished result moves into the output register when that is free.
    // ------------------------------------------------------------------
    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ctl            = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                ctl.eval = 1'b1;
                res_next = '0;
                unique case (item_reg.operation)
                    OP_OFFER:
                    begin
                        // A dominated candidate leaves the set as it is.
                        state_next = any_dom ? S_DONE : S_COMPACT;
                    end
                    OP_READ:
                    begin
                        if (read_hit)
                        begin
                            res_next = fill_entry('0, rd_entry);
                        end
                        state_next = S_DONE;
                    end
                    OP_CLEAR:
                    begin
                        count_next = '0;
                        state_next = S_DONE;
                    end
                    OP_NOP:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_COMPACT:
            begin
                priority if (any_removed)
                begin
                    ctl.compact = 1'b1;
                    count_next  = count_reg - 1'b1;
                end
                else if (count_reg == COUNT_W'(MAX_ENTRIES))
                begin
                    // Nothing was removed and there is no room: the candidate is dropped.
                    res_next.overflow = 1'b1;
                    state_next        = S_DONE;
                end
                else
                begin
                    ctl.insert        = 1'b1;
                    count_next        = count_reg + 1'b1;
                    res_next.accepted = 1'b1;
                    state_next        = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next          = res_reg;
                    rsp_next.set_size = 7'(count_reg);
                    rsp_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            count_reg          <= '0;
            num_objectives_reg <= NUM_OBJECTIVES_RESET;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            count_reg          <= count_next;
            num_objectives_reg <= num_objectives_next;
            rsp_valid_reg      <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Checks on the archive's own bookkeeping.
    // ------------------------------------------------------------------
    `PFA_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= COUNT_W'(MAX_ENTRIES))
    `PFA_ASSERT_NOW(a_accept_xor_overflow, rsp_valid_reg, !(rsp_reg.accepted && rsp_reg.overflow))
    `PFA_ASSERT_NOW(a_read_needs_entries, rsp_valid_reg && rsp_reg.entry_valid, rsp_reg.set_size != '0)
    `PFA_ASSERT_NEXT(a_compact_shrinks, (state_reg == S_COMPACT) && any_removed, count_reg == $past(count_reg) - 1'b1)

endmodule

// ===== hdl/pfa_cell.sv =====
`timescale 1ns / 1ps

module pfa_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  pfa_pkg::cell_ctl_t ctl,
    input  logic               valid,
    input  pfa_pkg::obj_vec_t  cand_obj,
    input  logic [2:0]         num_obj,
    input  pfa_pkg::entry_t    prev_entry,
    input  pfa_pkg::entry_t    next_entry,
    input  logic               next_removed,
    input  logic               hole_in,
    output pfa_pkg::entry_t    entry,
    output logic               removed,
    output logic               hole_out,
    output logic               dom_cand
);
    import pfa_pkg::*;

    entry_t entry_reg, entry_next;
    logic   removed_reg, removed_next;
    logic [MAX_OBJECTIVES-1:0] gt, lt;
    logic   cand_dom;

    // Per-objective compares of the stored entry against the candidate.
    always_comb
    begin
        for (int k = 0; k < MAX_OBJECTIVES; k++)
        begin
            gt[k] = (NOBJ_W'(k) < num_obj) && (entry_reg.obj[k] > cand_obj[k]);
            lt[k] = (NOBJ_W'(k) < num_obj) && (entry_reg.obj[k] < cand_obj[k]);
        end
    end

    assign dom_cand = valid && (|lt) && !(|gt);
    assign cand_dom = valid && (|gt) && !(|lt);
    assign hole_out = hole_in | removed_reg;

    // A compaction step moves every cell at or after the first hole up by one.
    always_comb
    begin
        entry_next   = entry_reg;
        removed_next = removed_reg;
        priority if (ctl.eval)
        begin
            removed_next = cand_dom;
        end
        else if (ctl.compact && hole_out)
        begin
            entry_next   = next_entry;
            removed_next = next_removed;
        end
        else if (ctl.insert)
        begin
            entry_next = prev_entry;
        end
        else
        begin
            entry_next   = entry_reg;
            removed_next = removed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            removed_reg <= 1'b0;
        end
        else
        begin
            removed_reg <= removed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry   = entry_reg;
    assign removed = removed_reg;

endmodule
